// File: src/piecewise_linear_interpolator_defines.svh
// Assertion macros shared by the interpolator checker
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// check cons in the same cycle as ante
`define PLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pli_pkg.sv
// Types and constants shared by the interpolator modules
package pli_pkg;

    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int SEG_INDEX_W = 4;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_X         = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT = CFG_INDEX_W'(1);

    localparam logic MODE_EVAL  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_ROUND,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] bound;
        logic signed [DATA_W-1:0] slope;
        logic signed [DATA_W-1:0] icpt;
    } seg_t;

    typedef struct packed {
        logic    load_x;
        logic    write_seg;
        logic    capture;
        logic    round;
        logic    load_out;
        logic    out_arith;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic below;
        logic hit;
    } dp_stat_t;

endpackage

// File: src/pli_cfg_regs.sv
// Configuration registers: minimum x and clamped segment count
module pli_cfg_regs #(
    parameter int MAX_SEGMENTS = 16,
    parameter int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [pli_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [pli_pkg::DATA_W-1:0]           cfg_data,
    output logic signed [pli_pkg::DATA_W-1:0]    min_x,
    output logic [CW-1:0]                        seg_limit
);
    import pli_pkg::*;

    logic signed [DATA_W-1:0] min_x_reg, min_x_next;
    logic [COUNT_W-1:0]       seg_count_reg, seg_count_next;
    logic                     wr_en;

    assign wr_en = cfg_valid && cfg_ready;

    always_comb
    begin
        min_x_next     = min_x_reg;
        seg_count_next = seg_count_reg;
        if (wr_en)
        begin
            case (cfg_index)
                CFG_MIN_X:         min_x_next = $signed(cfg_data);
                CFG_SEGMENT_COUNT: seg_count_next = cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= '0;
            seg_count_reg <= COUNT_W'(1);
        end
        else
        begin
            min_x_reg     <= min_x_next;
            seg_count_reg <= seg_count_next;
        end
    end

    assign min_x     = min_x_reg;
    assign seg_limit = ({{(32-COUNT_W){1'b0}}, seg_count_reg} > 32'(MAX_SEGMENTS))
                     ? CW'(MAX_SEGMENTS) : CW'(seg_count_reg);

endmodule

// File: src/pli_ctrl.sv
// Controller state machine: segment search sequencing and output handshake
module pli_ctrl #(
    parameter int MAX_SEGMENTS = 16,
    parameter int AW = $clog2(MAX_SEGMENTS),
    parameter int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic [CW-1:0]      seg_limit,
    input  pli_pkg::dp_stat_t  stat,
    output pli_pkg::dp_cmd_t   cmd,
    output logic [AW-1:0]      rd_addr
);
    import pli_pkg::*;

    ctrl_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    status_t       code_reg, code_next;
    logic          arith_reg, arith_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        code_next  = code_reg;
        arith_next = arith_reg;
        cmd        = '0;
        cmd.code   = ST_OK;
        rd_addr    = idx_reg;
        in_stall   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (mode == MODE_WRITE)
                        cmd.write_seg = 1'b1;
                    else
                    begin
                        cmd.load_x = 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                idx_next = '0;
                rd_addr  = '0;
                if (stat.below)
                begin
                    code_next  = ST_BELOW;
                    arith_next = 1'b0;
                    state_next = S_FINISH;
                end
                else if (seg_limit == '0)
                begin
                    code_next  = ST_ABOVE;
                    arith_next = 1'b0;
                    state_next = S_FINISH;
                end
                else
                    state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                cmd.capture = 1'b1;
                if (stat.hit)
                    state_next = S_ROUND;
                else if (CW'(idx_reg) + CW'(1) == seg_limit)
                begin
                    code_next  = ST_ABOVE;
                    arith_next = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    rd_addr  = idx_reg + AW'(1);
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                code_next  = ST_OK;
                arith_next = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.out_arith = arith_reg;
                    cmd.code      = code_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            code_reg      <= ST_OK;
            arith_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            code_reg      <= code_next;
            arith_reg     <= arith_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: src/pli_datapath.sv
// Datapath: segment memory, compare, multiply, round, saturate, output word
module pli_datapath #(
    parameter int MAX_SEGMENTS = 16,
    parameter int FRAC_BITS = 16,
    parameter int AW = $clog2(MAX_SEGMENTS)
) (
    input  logic                                   clk,
    input  pli_pkg::dp_cmd_t                       cmd,
    output pli_pkg::dp_stat_t                      stat,
    input  logic [AW-1:0]                          rd_addr,
    input  logic signed [pli_pkg::DATA_W-1:0]      min_x,
    input  logic signed [pli_pkg::DATA_W-1:0]      x_value,
    input  logic [pli_pkg::SEG_INDEX_W-1:0]        segment_index,
    input  logic signed [pli_pkg::DATA_W-1:0]      bound_x,
    input  logic signed [pli_pkg::DATA_W-1:0]      slope,
    input  logic signed [pli_pkg::DATA_W-1:0]      intercept,
    output logic signed [pli_pkg::DATA_W-1:0]      y_value,
    output logic [1:0]                             status
);
    import pli_pkg::*;

    localparam logic signed [63:0] HALF = (64'sd1 <<< FRAC_BITS) >>> 1;
    localparam logic signed [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    seg_t                     seg_mem [MAX_SEGMENTS];
    seg_t                     rd_seg_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [DATA_W-1:0] icpt_reg;
    logic signed [63:0]       rnd_reg, rnd_next;
    logic signed [DATA_W-1:0] y_reg, y_next;
    status_t                  status_reg, status_next;
    logic signed [64:0]       sum;
    logic                     sum_ovf;
    logic                     wr_ok;
    logic [AW-1:0]            wr_addr;

    assign wr_ok   = {{(32-SEG_INDEX_W){1'b0}}, segment_index} < 32'(MAX_SEGMENTS);
    assign wr_addr = AW'(segment_index);

    always_ff @(posedge clk)
    begin
        if (cmd.write_seg && wr_ok)
            seg_mem[wr_addr] <= '{bound: bound_x, slope: slope, icpt: intercept};
        rd_seg_reg <= seg_mem[rd_addr];
    end

    assign stat.below = x_reg < min_x;
    assign stat.hit   = x_reg <= rd_seg_reg.bound;

    assign prod_next = x_reg * rd_seg_reg.slope;
    assign rnd_next  = (prod_reg + HALF) >>> FRAC_BITS;

    assign sum     = {rnd_reg[63], rnd_reg} + {{(65-DATA_W){icpt_reg[DATA_W-1]}}, icpt_reg};
    assign sum_ovf = !((&sum[64:DATA_W-1]) || !(|sum[64:DATA_W-1]));

    always_comb
    begin
        if (!cmd.out_arith)
        begin
            y_next      = '0;
            status_next = cmd.code;
        end
        else if (sum_ovf)
        begin
            y_next      = sum[64] ? Y_MIN : Y_MAX;
            status_next = ST_SAT;
        end
        else
        begin
            y_next      = sum[DATA_W-1:0];
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
            x_reg <= x_value;
        if (cmd.capture)
        begin
            prod_reg <= prod_next;
            icpt_reg <= rd_seg_reg.icpt;
        end
        if (cmd.round)
            rnd_reg <= rnd_next;
        if (cmd.load_out)
        begin
            y_reg      <= y_next;
            status_reg <= status_next;
        end
    end

    assign y_value = y_reg;
    assign status  = status_reg;

endmodule

// File: src/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator
//
//   channel   direction  handshake              word
//   input     in         in_valid / in_stall    mode, x_value, segment_index,
//                                               bound_x, slope, intercept
//   result    out        out_valid / out_stall  y_value, status
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A segment write is taken in idle, which then accepts the next word. An evaluate
// goes from idle through start, search (one segment compared per cycle through the
// segment memory read port), round on a hit and finish back to idle; with no hit it
// skips round, and below range or an empty table goes from start straight to finish.
// Reset clears control and configuration; segment memory is not cleared.
// A stalled result holds in the output register; only the finish state waits for it.
module piecewise_linear_interpolator #(
    parameter int MAX_SEGMENTS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   mode,
    input  logic signed [pli_pkg::DATA_W-1:0]      x_value,
    input  logic [pli_pkg::SEG_INDEX_W-1:0]        segment_index,
    input  logic signed [pli_pkg::DATA_W-1:0]      bound_x,
    input  logic signed [pli_pkg::DATA_W-1:0]      slope,
    input  logic signed [pli_pkg::DATA_W-1:0]      intercept,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pli_pkg::DATA_W-1:0]      y_value,
    output logic [1:0]                             status,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pli_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pli_pkg::DATA_W-1:0]             cfg_data
);
    import pli_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic signed [DATA_W-1:0] min_x;
    logic [CW-1:0]            seg_limit;
    dp_cmd_t                  cmd;
    dp_stat_t                 stat;
    logic [AW-1:0]            rd_addr;

    assign cfg_ready = 1'b1;

    pli_cfg_regs #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .CW           (CW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .min_x     (min_x),
        .seg_limit (seg_limit)
    );

    pli_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .seg_limit (seg_limit),
        .stat      (stat),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    pli_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FRAC_BITS    (FRAC_BITS),
        .AW           (AW)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .stat          (stat),
        .rd_addr       (rd_addr),
        .min_x         (min_x),
        .x_value       (x_value),
        .segment_index (segment_index),
        .bound_x       (bound_x),
        .slope         (slope),
        .intercept     (intercept),
        .y_value       (y_value),
        .status        (status)
    );

endmodule

// File: src/pli_checker.sv
// Port-level checker for the interpolator and its bind
`include "piecewise_linear_interpolator_defines.svh"

module pli_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              mode,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [pli_pkg::DATA_W-1:0] y_value,
    input logic [1:0]                        status
);
    import pli_pkg::*;

    `PLI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(y_value) && $stable(status), "stalled result word changed")

    `PLI_ASSERT_NOW(a_range_zero, out_valid && (status == ST_BELOW || status == ST_ABOVE),
        y_value == '0, "out of range result word not zero")

    `PLI_ASSERT_NOW(a_sat_clamp, out_valid && status == ST_SAT,
        y_value == 32'sh7FFF_FFFF || y_value == 32'sh8000_0000, "saturated word not clamped")

    `PLI_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && mode == MODE_EVAL,
        in_stall, "evaluate word accepted without going busy")

endmodule

bind piecewise_linear_interpolator pli_checker u_checker (.*);

// File: verif/piecewise_linear_interpolator_tb.sv
// Self-checking testbench for the piecewise linear interpolator: random table, config and traffic
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;
    import pli_pkg::*;

    localparam int SEG_SLOTS    = 16;
    localparam int FRAC         = 16;
    localparam int Y_MAX        = 32'sh7FFF_FFFF;
    localparam int Y_MIN        = 32'sh8000_0000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 145;

    typedef struct {
        logic                   mode;
        int                     x;
        logic [SEG_INDEX_W-1:0] idx;
        int                     bnd;
        int                     slp;
        int                     icp;
    } in_word_t;

    typedef struct {
        int      y;
        status_t st;
    } y_word_t;

    class interp_checker;
        int                  bound_mem [SEG_SLOTS];
        int                  slope_mem [SEG_SLOTS];
        int                  icpt_mem  [SEG_SLOTS];
        int                  min_x_reg;
        logic [COUNT_W-1:0]  count_reg;
        y_word_t             expected_y_q [$];
        int                  errors;

        function new();
            int i;
            for (i = 0; i < SEG_SLOTS; i++)
            begin
                bound_mem[i] = 0;
                slope_mem[i] = 0;
                icpt_mem[i]  = 0;
            end
            min_x_reg = 0;
            count_reg = COUNT_W'(1);
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == CFG_MIN_X)
                min_x_reg = data;
            else if (idx == CFG_SEGMENT_COUNT)
                count_reg = data[COUNT_W-1:0];
        endfunction

        function y_word_t interpolate(int x);
            y_word_t r;
            int      n;
            int      i;
            bit      hit;
            longint  prod;
            longint  sum;
            r.y  = 0;
            r.st = ST_ABOVE;
            hit  = 0;
            if (x < min_x_reg)
                r.st = ST_BELOW;
            else
            begin
                n = (count_reg > SEG_SLOTS) ? SEG_SLOTS : int'(count_reg);
                for (i = 0; i < n && !hit; i++)
                begin
                    if (x <= bound_mem[i])
                    begin
                        hit  = 1;
                        prod = longint'(slope_mem[i]) * longint'(x);
                        sum  = ((prod + (longint'(1) <<< (FRAC - 1))) >>> FRAC)
                               + longint'(icpt_mem[i]);
                        if (sum > longint'(Y_MAX))
                        begin
                            r.y  = Y_MAX;
                            r.st = ST_SAT;
                        end
                        else if (sum < longint'(Y_MIN))
                        begin
                            r.y  = Y_MIN;
                            r.st = ST_SAT;
                        end
                        else
                        begin
                            r.y  = int'(sum);
                            r.st = ST_OK;
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_word(in_word_t w);
            if (w.mode == MODE_WRITE)
            begin
                bound_mem[w.idx] = w.bnd;
                slope_mem[w.idx] = w.slp;
                icpt_mem[w.idx]  = w.icp;
            end
            else
                expected_y_q.push_back(interpolate(w.x));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_word(logic [DATA_W-1:0] y, logic [1:0] st);
            y_word_t e;
            if (expected_y_q.size() == 0)
            begin
                report($sformatf("unexpected result y=%h status=%0d", y, st));
                return;
            end
            e = expected_y_q.pop_front();
            if (st !== e.st)
                report($sformatf("status %0d, expected %0d", st, e.st));
            if (y !== DATA_W'(e.y))
                report($sformatf("y_value %h, expected %h", y, DATA_W'(e.y)));
        endtask

        function int pending();
            return expected_y_q.size();
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          mode = MODE_EVAL;
    logic signed [DATA_W-1:0]      x_value = '0;
    logic [SEG_INDEX_W-1:0]        segment_index = '0;
    logic signed [DATA_W-1:0]      bound_x = '0;
    logic signed [DATA_W-1:0]      slope = '0;
    logic signed [DATA_W-1:0]      intercept = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [DATA_W-1:0]      y_value;
    logic [1:0]                    status;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [DATA_W-1:0]             cfg_data = '0;

    interp_checker sb = new();
    bit            tx_quiet = 0;
    bit            rx_quiet = 0;
    bit            long_hold_req = 0;

    piecewise_linear_interpolator #(
        .MAX_SEGMENTS(SEG_SLOTS),
        .FRAC_BITS(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .x_value(x_value),
        .segment_index(segment_index),
        .bound_x(bound_x),
        .slope(slope),
        .intercept(intercept),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .y_value(y_value),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic in_word_t seg_word(int idx, int b, int s, int c);
        in_word_t w;
        w.mode = MODE_WRITE;
        w.x    = $urandom;
        w.idx  = SEG_INDEX_W'(idx);
        w.bnd  = b;
        w.slp  = s;
        w.icp  = c;
        return w;
    endfunction

    function automatic in_word_t eval_word(int x);
        in_word_t w;
        w.mode = MODE_EVAL;
        w.x    = x;
        w.idx  = SEG_INDEX_W'($urandom_range(0, SEG_SLOTS - 1));
        w.bnd  = $urandom;
        w.slp  = $urandom;
        w.icp  = $urandom;
        return w;
    endfunction

    function automatic int pick_slope();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            6, 7:    return int'($urandom_range(0, 6)) - 3;
            8:       return Y_MAX;
            default: return Y_MIN;
        endcase
    endfunction

    function automatic int pick_icpt();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            7:          return Y_MAX;
            8:          return Y_MIN;
            default:    return 0;
        endcase
    endfunction

    function automatic in_word_t make_eval();
        int x;
        case ($urandom_range(0, 9))
            0, 1:    x = $urandom;
            2, 3, 4: x = sb.bound_mem[$urandom_range(0, SEG_SLOTS - 1)]
                         + int'($urandom_range(0, 4)) - 2;
            5:       x = sb.bound_mem[$urandom_range(0, SEG_SLOTS - 1)]
                         - int'($urandom_range(0, 32'h0000_FFFF));
            6:       x = sb.min_x_reg + int'($urandom_range(0, 2)) - 1;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       x = Y_MIN;
                    1:       x = Y_MAX;
                    2:       x = 0;
                    default: x = -1;
                endcase
            end
            8:       x = {16'($urandom_range(0, 32'h0000_FFFF)), 16'h8000};
            default: x = int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        endcase
        return eval_word(x);
    endfunction

    task automatic send_word(in_word_t w);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= w.mode;
        x_value       <= w.x;
        segment_index <= w.idx;
        bound_x       <= w.bnd;
        slope         <= w.slp;
        intercept     <= w.icp;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
    endtask

    // rewrite every slot with ascending bounds so the search runs deep
    task automatic refresh_table();
        int unsigned stride;
        int unsigned room;
        longint      base;
        int          i;
        if ($urandom_range(0, 1))
            stride = $urandom_range(1, 32'h0800_0000);
        else
            stride = $urandom_range(1, 256);
        room = 32'hFFFF_FFFF - 15 * stride;
        base = longint'(Y_MIN) + longint'($urandom_range(0, room));
        for (i = 0; i < SEG_SLOTS; i++)
            send_word(seg_word(i, int'(base + longint'(i) * longint'(stride)),
                               pick_slope(), pick_icpt()));
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic set_window(int min_val, logic [COUNT_W-1:0] cnt);
        logic [DATA_W-1:0] d;
        d          = $urandom;
        d[COUNT_W-1:0] = cnt;
        write_cfg(CFG_MIN_X, min_val);
        write_cfg(CFG_INDEX_W'($urandom_range(CFG_SEGMENT_COUNT + 1, 2**CFG_INDEX_W - 1)),
                  $urandom);
        write_cfg(CFG_SEGMENT_COUNT, d);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int min_val, logic [COUNT_W-1:0] cnt, bit squeeze);
        int sent;
        int k;
        set_window(min_val, cnt);
        tx_quiet = squeeze || ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if (squeeze)
            long_hold_req = 1;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            k = $urandom_range(0, 99);
            if (k < 2)
            begin
                refresh_table();
                sent += SEG_SLOTS;
            end
            else if (k < 14)
            begin
                send_word(seg_word($urandom_range(0, SEG_SLOTS - 1), $urandom,
                                   pick_slope(), pick_icpt()));
                sent++;
            end
            else
            begin
                send_word(make_eval());
                sent++;
            end
        end
        drain_block();
        tx_quiet = 0;
    endtask

    initial
    begin : result_sink
        int wait_n;
        forever
        begin
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 0;
            end
            else
            begin
                wait_n = rx_quiet ? 0 : $urandom_range(0, 18);
                if (wait_n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            sb.check_word(y_value, status);
        end
    end

    initial
    begin : stimulus
        int i;
        int s;
        int c;
        int p;
        int min_val;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window: min_x zero, one segment
        send_word(seg_word(0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000));
        for (i = 1; i < SEG_SLOTS - 1; i++)
        begin
            s = (i % 2) ? i * 32'sh0000_4000 : -(i <<< 16);
            c = i * 32'sh0012_3456;
            if (i == SEG_SLOTS - 2)
            begin
                s = Y_MAX;
                c = Y_MIN;
            end
            send_word(seg_word(i, i * 32'sh0800_0000, s, c));
        end
        send_word(seg_word(SEG_SLOTS - 1, Y_MAX, Y_MIN, Y_MAX));
        send_word(eval_word(-1));
        send_word(eval_word(Y_MIN));
        send_word(eval_word(0));
        send_word(eval_word(32'sh0001_0000));
        send_word(eval_word(32'sh0001_0001));
        send_word(eval_word(Y_MAX));
        drain_block();

        set_window(Y_MIN, COUNT_W'(SEG_SLOTS));
        send_word(eval_word(Y_MAX));
        send_word(eval_word(Y_MIN));
        send_word(eval_word(32'sh6FFF_0000));
        drain_block();

        run_phase(Y_MIN, COUNT_W'(SEG_SLOTS), 1);
        run_phase(Y_MAX, COUNT_W'(SEG_SLOTS), 0);
        run_phase(0, COUNT_W'(0), 0);
        run_phase($urandom, COUNT_W'(2**COUNT_W - 1), 0);
        run_phase(-int'($urandom_range(0, 32'h7FFF_FFFF)), COUNT_W'(SEG_SLOTS + 1), 0);
        run_phase($urandom, COUNT_W'(1), 0);
        for (p = 0; p < 6; p++)
        begin
            case ($urandom_range(0, 2))
                0:       min_val = $urandom;
                1:       min_val = Y_MIN;
                default: min_val = int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            endcase
            if ($urandom_range(0, 3) == 0)
                run_phase(min_val, COUNT_W'($urandom_range(0, 2**COUNT_W - 1)), 0);
            else
                run_phase(min_val, COUNT_W'($urandom_range(1, SEG_SLOTS)), 0);
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
